// File: design/lidar_polar_to_cartesian_point_defines.svh
// Assertion macros for the lidar point projection block.
`ifndef LIDAR_POLAR_TO_CARTESIAN_POINT_DEFINES_SVH
`define LIDAR_POLAR_TO_CARTESIAN_POINT_DEFINES_SVH
`ifndef SYNTHESIS
`define LP2C_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lp2c: same-cycle check failed");
`define LP2C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lp2c: next-cycle check failed");
`else
`define LP2C_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LP2C_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/lp2c_pkg.sv
// Shared types and constants of the lidar point projection block.
package lp2c_pkg;

   localparam int QB   = 30;            // fraction bits of the trig values
   localparam int XW   = 30;            // reduced angle and its square
   localparam int TW   = 31;            // series accumulator, holds 1.0
   localparam int SCW  = 32;            // signed sine or cosine
   localparam logic [TW-1:0] QONE = 31'h4000_0000;
   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

   localparam int TERM_LAT = 3;
   localparam int COS_N = 5;
   localparam int SIN_N = 4;
   localparam int COS_DIV [COS_N] = '{90, 56, 30, 12, 2};
   localparam int SIN_DIV [SIN_N] = '{72, 42, 20, 6};
   localparam int SC_LAT = 2 + COS_N * TERM_LAT + 1;

   localparam int SQ_STEPS = 25;        // bit pairs of a 50 bit sum of squares
   localparam int SQW = 50;
   localparam int RW  = 51;

   localparam int RSP_DW = 120;         // 115 bits of fields, padded to bytes

   typedef enum logic [1:0] {
      CSR_COLUMNS_LOG2 = 2'd0,
      CSR_BEAM_OFFSET  = 2'd1,
      CSR_MIN_RANGE    = 2'd2,
      CSR_MAX_RANGE    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

endpackage

// File: design/lp2c_term.sv
// One Taylor series cell: t_o = 1 - (x2 * t_i) / DIV, three register stages.
module lp2c_term
   import lp2c_pkg::*;
#(
   parameter int DIV = 2
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [XW-1:0] x2_i,
   input  logic [TW-1:0] t_i,
   output logic [XW-1:0] x2_o,
   output logic [TW-1:0] t_o
);

   localparam logic [XW-1:0] RECIP = XW'((64'd1 << QB) / DIV);
   localparam logic [XW-1:0] DIV_C = XW'(DIV);

   logic [XW+TW-1:0] prod_a;
   logic [2*XW-1:0]  prod_b;
   logic [XW-1:0]    v_in, q0_in, rem, qfix;
   logic [TW-1:0]    t_in;
   logic [XW-1:0]    v_ff, x2a_ff, q0_ff, vb_ff, x2b_ff, x2c_ff;
   logic [TW-1:0]    t_ff;

   always_comb begin
      prod_a = (XW+TW)'(x2_i) * (XW+TW)'(t_i);
      v_in   = prod_a[QB+XW-1:QB];
      // reciprocal estimate is low by at most one
      prod_b = (2*XW)'(v_ff) * (2*XW)'(RECIP);
      q0_in  = prod_b[2*XW-1:QB];
      rem    = vb_ff - q0_ff * DIV_C;
      qfix   = (rem >= DIV_C) ? q0_ff + XW'(1) : q0_ff;
      t_in   = QONE - TW'(qfix);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         v_ff   <= v_in;
         x2a_ff <= x2_i;
         q0_ff  <= q0_in;
         vb_ff  <= v_ff;
         x2b_ff <= x2a_ff;
         t_ff   <= t_in;
         x2c_ff <= x2b_ff;
      end
   end

   assign x2_o = x2c_ff;
   assign t_o  = t_ff;

endmodule

// File: design/lp2c_sincos.sv
// Sine and cosine in Q30 of an angle in 1/2^ANGLE_BITS turn, fixed latency.
module lp2c_sincos
   import lp2c_pkg::*;
#(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ANGLE_BITS-1:0] angle_i,
   output logic signed [SCW-1:0] sin_o,
   output logic signed [SCW-1:0] cos_o
);

   localparam int AB  = ANGLE_BITS;
   localparam int XDL = SIN_N * TERM_LAT;
   localparam int SDL = (COS_N - SIN_N) * TERM_LAT - 1;
   localparam int QDL = 1 + COS_N * TERM_LAT;
   localparam logic [AB-2:0] QUARTER = (AB-1)'(1) << (AB - 2);
   localparam logic [AB-3:0] EIGHTH  = (AB-2)'(1) << (AB - 3);

   logic [AB-3:0]    r_raw, r_red;
   logic             swap_in;
   logic [AB+30:0]   prod_x;
   logic [2*XW-1:0]  prod_sq;
   logic [XW+TW-1:0] prod_sn;
   logic [XW-1:0]    x1_in, x2_in, sn_in;
   logic [XW-1:0]    x1_ff, x2_ff, xs2_ff, sn_ff;
   logic [1:0]       q1_ff;
   logic             sw1_ff;
   logic [XW-1:0]    xd_ff [XDL];
   logic [XW-1:0]    sd_ff [SDL];
   logic [1:0]       qd_ff [QDL];
   logic             swd_ff [QDL];
   logic [XW-1:0]    cx2 [COS_N+1];
   logic [TW-1:0]    ctt [COS_N+1];
   logic [XW-1:0]    sx2 [SIN_N+1];
   logic [TW-1:0]    stt [SIN_N+1];
   logic [TW-1:0]    sv, cv;
   logic signed [SCW-1:0] s_ext, c_ext, sin_in, cos_in, sin_ff, cos_ff;

   // octant reduction
   always_comb begin
      r_raw   = angle_i[AB-3:0];
      swap_in = r_raw > EIGHTH;
      r_red   = swap_in ? (AB-2)'(QUARTER - {1'b0, r_raw}) : r_raw;
      prod_x  = (AB+31)'(r_red) * (AB+31)'(TWO_PI_Q30);
      x1_in   = prod_x[AB+XW-1:AB];
      prod_sq = (2*XW)'(x1_ff) * (2*XW)'(x1_ff);
      x2_in   = prod_sq[2*XW-1:QB];
   end

   assign cx2[0] = x2_ff;
   assign ctt[0] = QONE;
   assign sx2[0] = x2_ff;
   assign stt[0] = QONE;

   for (genvar i = 0; i < COS_N; i++) begin : g_cos
      lp2c_term #(.DIV(COS_DIV[i])) u_term (
         .clock  (clock),
         .enable (enable),
         .x2_i   (cx2[i]),
         .t_i    (ctt[i]),
         .x2_o   (cx2[i+1]),
         .t_o    (ctt[i+1])
      );
   end

   for (genvar i = 0; i < SIN_N; i++) begin : g_sin
      lp2c_term #(.DIV(SIN_DIV[i])) u_term (
         .clock  (clock),
         .enable (enable),
         .x2_i   (sx2[i]),
         .t_i    (stt[i]),
         .x2_o   (sx2[i+1]),
         .t_o    (stt[i+1])
      );
   end

   always_comb begin
      prod_sn = (XW+TW)'(xd_ff[XDL-1]) * (XW+TW)'(stt[SIN_N]);
      sn_in   = prod_sn[QB+XW-1:QB];
      sv      = swd_ff[QDL-1] ? ctt[COS_N] : TW'(sd_ff[SDL-1]);
      cv      = swd_ff[QDL-1] ? TW'(sd_ff[SDL-1]) : ctt[COS_N];
      s_ext   = signed'(SCW'(sv));
      c_ext   = signed'(SCW'(cv));
      unique case (quad_type'(qd_ff[QDL-1]))
         QUAD_0: begin
            sin_in = s_ext;
            cos_in = c_ext;
         end
         QUAD_1: begin
            sin_in = c_ext;
            cos_in = -s_ext;
         end
         QUAD_2: begin
            sin_in = -s_ext;
            cos_in = -c_ext;
         end
         QUAD_3: begin
            sin_in = -c_ext;
            cos_in = s_ext;
         end
         default: begin
            sin_in = s_ext;
            cos_in = c_ext;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff  <= x1_in;
         q1_ff  <= angle_i[AB-1:AB-2];
         sw1_ff <= swap_in;
         x2_ff  <= x2_in;
         xs2_ff <= x1_ff;
         xd_ff[0] <= xs2_ff;
         for (int i = 1; i < XDL; i++) xd_ff[i] <= xd_ff[i-1];
         sn_ff <= sn_in;
         sd_ff[0] <= sn_ff;
         for (int i = 1; i < SDL; i++) sd_ff[i] <= sd_ff[i-1];
         qd_ff[0]  <= q1_ff;
         swd_ff[0] <= sw1_ff;
         for (int i = 1; i < QDL; i++) begin
            qd_ff[i]  <= qd_ff[i-1];
            swd_ff[i] <= swd_ff[i-1];
         end
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

// File: design/lp2c_sqrt_cell.sv
// One restoring square root step on bit pair STEP, registered.
module lp2c_sqrt_cell
   import lp2c_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic           clock,
   input  logic           enable,
   input  logic [SQW-1:0] n_i,
   input  logic [RW-1:0]  r_i,
   output logic [SQW-1:0] n_o,
   output logic [RW-1:0]  r_o
);

   localparam logic [RW-1:0] BIT = RW'(1) << (2 * STEP);

   logic [RW-1:0]  trial, r_in;
   logic [SQW-1:0] n_in;
   logic           take;
   logic [SQW-1:0] n_ff;
   logic [RW-1:0]  r_ff;

   always_comb begin
      trial = r_i + BIT;
      take  = RW'(n_i) >= trial;
      n_in  = take ? n_i - SQW'(trial) : n_i;
      r_in  = take ? (r_i >> 1) + BIT : (r_i >> 1);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n_ff <= n_in;
         r_ff <= r_in;
      end
   end

   assign n_o = n_ff;
   assign r_o = r_ff;

endmodule

// File: design/lidar_polar_to_cartesian_point.sv
// Throughput: one word per cycle while the skid entry is empty; every stage is a register,
// the depth is set by the trig chains (18 stages) and the 25 square root cells.
// A two-entry output (register plus skid) makes req_tready a registered signal.
// Reset (synchronous, active high) clears all valid bits and loads register defaults.
module lidar_polar_to_cartesian_point
   import lp2c_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int RANGE_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   // range_mm, measurement_id, altitude_angle, azimuth_angle, signal_in (low first)
   input  logic [((RANGE_BITS+2*ANGLE_BITS+27+7)/8)*8-1:0] req_tdata,
   // column_valid
   input  logic [0:0]           req_tuser,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // point_x, point_y, point_z, point_range, intensity (low first)
   output logic [RSP_DW-1:0]    rsp_tdata,
   // point_valid
   output logic [0:0]           rsp_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_we,
   input  logic [1:0]           csr_addr,
   input  logic [RANGE_BITS-1:0] csr_wdata
);

`include "lidar_polar_to_cartesian_point_defines.svh"

   localparam int AB  = ANGLE_BITS;
   localparam int RB  = RANGE_BITS;
   localparam int DW  = RB + 4;                 // signed distance along the beam
   localparam int PW  = DW + SCW;               // product with a Q30 value
   localparam int NW  = 15;                     // rounded offset terms
   localparam int EW  = (DW + 1 > 26) ? DW + 1 : 26;
   localparam int SQD = SQ_STEPS;               // side data through the root cells
   localparam int LAT = 1 + SC_LAT + 6 + SQ_STEPS + 1;
   localparam logic signed [PW-1:0] RND_POS = PW'(64'd536870912);
   localparam logic signed [PW-1:0] RND_NEG = PW'(64'd536870911);
   localparam logic signed [EW-1:0] SAT_HI  = EW'(24'hFF_FFFF);
   localparam logic signed [EW-1:0] SAT_LO  = -SAT_HI - EW'(1);

   // ---------------------------------------------------------------- helpers
   // Q30 product back to integer, ties away from zero
   function automatic logic signed [PW-QB-1:0] rnd(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = p + (p[PW-1] ? RND_NEG : RND_POS);
      return s[PW-1:QB];
   endfunction

   function automatic logic signed [24:0] sat25(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] c;
      c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
      return c[24:0];
   endfunction

   // ---------------------------------------------------------------- registers
   logic [3:0]    cl_ff;
   logic [12:0]   boff_ff;
   logic [RB-1:0] minr_ff, maxr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_ff   <= 4'd10;
         boff_ff <= '0;
         minr_ff <= '0;
         maxr_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_COLUMNS_LOG2: cl_ff   <= csr_wdata[3:0];
            CSR_BEAM_OFFSET:  boff_ff <= csr_wdata[12:0];
            CSR_MIN_RANGE:    minr_ff <= csr_wdata;
            CSR_MAX_RANGE:    maxr_ff <= csr_wdata;
            default:          cl_ff   <= cl_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // The whole pipe moves together; it stops only while the skid entry is full.
   logic           advance;
   logic           sk_valid_ff;
   logic [LAT-1:0] vld_ff;

   assign advance    = !sk_valid_ff;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ---------------------------------------------------------------- stage 0
   // unpack, limit check, encoder angle
   logic [RB-1:0]        range_w;
   logic [10:0]          mid_w;
   logic [AB-1:0]        alt_w, azi_w;
   logic [15:0]          sig_w;
   logic [3:0]           cl_c;
   logic [4:0]           sh;
   logic [AB+10:0]       mid_sh;
   logic [AB-1:0]        enc_in, theta_in;
   logic signed [DW-1:0] d_in;
   logic                 ok_in;

   always_comb begin
      range_w  = req_tdata[RB-1:0];
      mid_w    = req_tdata[RB+10:RB];
      alt_w    = req_tdata[RB+10+AB:RB+11];
      azi_w    = req_tdata[RB+10+2*AB:RB+11+AB];
      sig_w    = req_tdata[RB+26+2*AB:RB+11+2*AB];
      ok_in    = req_tuser[0] && (range_w >= minr_ff) && (range_w <= maxr_ff);
      // column count clamps to 512..2048
      cl_c     = (cl_ff < 4'd9) ? 4'd9 : ((cl_ff > 4'd11) ? 4'd11 : cl_ff);
      sh       = 5'(AB) - {1'b0, cl_c};
      mid_sh   = (AB+11)'(mid_w) << sh;
      enc_in   = {AB{1'b0}} - mid_sh[AB-1:0];
      theta_in = enc_in - azi_w;
      d_in     = signed'(DW'({range_w, 3'b000})) - signed'(DW'(boff_ff));
   end

   logic [AB-1:0]        alt0_ff, th0_ff, en0_ff;
   logic signed [DW-1:0] d0_ff;
   logic [12:0]          n0_ff;
   logic [15:0]          sig0_ff;
   logic                 ok0_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         alt0_ff <= alt_w;
         th0_ff  <= theta_in;
         en0_ff  <= enc_in;
         d0_ff   <= d_in;
         n0_ff   <= boff_ff;
         sig0_ff <= sig_w;
         ok0_ff  <= ok_in;
      end
   end

   // ---------------------------------------------------------------- trig units
   logic signed [SCW-1:0] sp, cp, st, ct, se, ce;

   lp2c_sincos #(.ANGLE_BITS(AB)) u_sc_alt (
      .clock (clock), .enable (advance), .angle_i (alt0_ff), .sin_o (sp), .cos_o (cp)
   );
   lp2c_sincos #(.ANGLE_BITS(AB)) u_sc_theta (
      .clock (clock), .enable (advance), .angle_i (th0_ff), .sin_o (st), .cos_o (ct)
   );
   lp2c_sincos #(.ANGLE_BITS(AB)) u_sc_enc (
      .clock (clock), .enable (advance), .angle_i (en0_ff), .sin_o (se), .cos_o (ce)
   );

   // side data waits for the trig units
   logic signed [DW-1:0] d_dl_ff   [SC_LAT];
   logic [12:0]          n_dl_ff   [SC_LAT];
   logic [15:0]          sig_dl_ff [SC_LAT];
   logic                 ok_dl_ff  [SC_LAT];

   always_ff @(posedge clock) begin
      if (advance) begin
         d_dl_ff[0]   <= d0_ff;
         n_dl_ff[0]   <= n0_ff;
         sig_dl_ff[0] <= sig0_ff;
         ok_dl_ff[0]  <= ok0_ff;
         for (int i = 1; i < SC_LAT; i++) begin
            d_dl_ff[i]   <= d_dl_ff[i-1];
            n_dl_ff[i]   <= n_dl_ff[i-1];
            sig_dl_ff[i] <= sig_dl_ff[i-1];
            ok_dl_ff[i]  <= ok_dl_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- P1: products
   logic signed [PW-1:0]  n_ext;
   logic signed [PW-1:0]  pdc_in, pds_in, pnc_in, pns_in;
   logic signed [PW-1:0]  pdc_ff, pds_ff, pnc_ff, pns_ff;
   logic signed [SCW-1:0] ct1_ff, st1_ff;
   logic [15:0]           sig1_ff;
   logic                  ok1_ff;

   always_comb begin
      n_ext  = signed'(PW'(n_dl_ff[SC_LAT-1]));
      pdc_in = PW'(d_dl_ff[SC_LAT-1]) * PW'(cp);
      pds_in = PW'(d_dl_ff[SC_LAT-1]) * PW'(sp);
      pnc_in = n_ext * PW'(ce);
      pns_in = n_ext * PW'(se);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pdc_ff  <= pdc_in;
         pds_ff  <= pds_in;
         pnc_ff  <= pnc_in;
         pns_ff  <= pns_in;
         ct1_ff  <= ct;
         st1_ff  <= st;
         sig1_ff <= sig_dl_ff[SC_LAT-1];
         ok1_ff  <= ok_dl_ff[SC_LAT-1];
      end
   end

   // ---------------------------------------------------------------- P2: round
   logic signed [DW-1:0]  h2_ff, z2_ff;
   logic signed [NW-1:0]  nc2_ff, ns2_ff;
   logic signed [SCW-1:0] ct2_ff, st2_ff;
   logic [15:0]           sig2_ff;
   logic                  ok2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         h2_ff   <= DW'(rnd(pdc_ff));
         z2_ff   <= DW'(rnd(pds_ff));
         nc2_ff  <= NW'(rnd(pnc_ff));
         ns2_ff  <= NW'(rnd(pns_ff));
         ct2_ff  <= ct1_ff;
         st2_ff  <= st1_ff;
         sig2_ff <= sig1_ff;
         ok2_ff  <= ok1_ff;
      end
   end

   // ---------------------------------------------------------------- P3: rotate
   logic signed [PW-1:0] phc_ff, phs_ff;
   logic signed [DW-1:0] z3_ff;
   logic signed [NW-1:0] nc3_ff, ns3_ff;
   logic [15:0]          sig3_ff;
   logic                 ok3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         phc_ff  <= PW'(h2_ff) * PW'(ct2_ff);
         phs_ff  <= PW'(h2_ff) * PW'(st2_ff);
         z3_ff   <= z2_ff;
         nc3_ff  <= nc2_ff;
         ns3_ff  <= ns2_ff;
         sig3_ff <= sig2_ff;
         ok3_ff  <= ok2_ff;
      end
   end

   // ---------------------------------------------------------------- P4: sum, clip
   // invalid pixels are zeroed here, so the norm below comes out zero too
   logic signed [EW-1:0] xs_in, ys_in, zs_in;
   logic signed [24:0]   x4_ff, y4_ff, z4_ff;
   logic [15:0]          sig4_ff;
   logic                 ok4_ff;

   always_comb begin
      xs_in = EW'(rnd(phc_ff)) + EW'(nc3_ff);
      ys_in = EW'(rnd(phs_ff)) + EW'(ns3_ff);
      zs_in = EW'(z3_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x4_ff   <= ok3_ff ? sat25(xs_in) : '0;
         y4_ff   <= ok3_ff ? sat25(ys_in) : '0;
         z4_ff   <= ok3_ff ? sat25(zs_in) : '0;
         sig4_ff <= ok3_ff ? sig3_ff : '0;
         ok4_ff  <= ok3_ff;
      end
   end

   // ---------------------------------------------------------------- P5, P6: squares
   logic signed [49:0] xx_in, yy_in, zz_in;
   logic [48:0]        xx_ff, yy_ff, zz_ff;
   logic signed [24:0] x5_ff, y5_ff, z5_ff, x6_ff, y6_ff, z6_ff;
   logic [15:0]        sig5_ff, sig6_ff;
   logic               ok5_ff, ok6_ff;
   logic [SQW-1:0]     sq_ff;

   always_comb begin
      xx_in = 50'(x4_ff) * 50'(x4_ff);
      yy_in = 50'(y4_ff) * 50'(y4_ff);
      zz_in = 50'(z4_ff) * 50'(z4_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xx_ff   <= xx_in[48:0];
         yy_ff   <= yy_in[48:0];
         zz_ff   <= zz_in[48:0];
         x5_ff   <= x4_ff;
         y5_ff   <= y4_ff;
         z5_ff   <= z4_ff;
         sig5_ff <= sig4_ff;
         ok5_ff  <= ok4_ff;
         sq_ff   <= SQW'(xx_ff) + SQW'(yy_ff) + SQW'(zz_ff);
         x6_ff   <= x5_ff;
         y6_ff   <= y5_ff;
         z6_ff   <= z5_ff;
         sig6_ff <= sig5_ff;
         ok6_ff  <= ok5_ff;
      end
   end

   // ---------------------------------------------------------------- root cells
   // one bit pair per cell, top pair first; the remainder rides along
   logic [SQW-1:0] sq_n [SQ_STEPS+1];
   logic [RW-1:0]  sq_r [SQ_STEPS+1];

   assign sq_n[0] = sq_ff;
   assign sq_r[0] = '0;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_root
      lp2c_sqrt_cell #(.STEP(SQ_STEPS - 1 - i)) u_cell (
         .clock  (clock),
         .enable (advance),
         .n_i    (sq_n[i]),
         .r_i    (sq_r[i]),
         .n_o    (sq_n[i+1]),
         .r_o    (sq_r[i+1])
      );
   end

   logic signed [24:0] x_dl_ff [SQD];
   logic signed [24:0] y_dl_ff [SQD];
   logic signed [24:0] z_dl_ff [SQD];
   logic [15:0]        s_dl_ff [SQD];
   logic               v_dl_ff [SQD];

   always_ff @(posedge clock) begin
      if (advance) begin
         x_dl_ff[0] <= x6_ff;
         y_dl_ff[0] <= y6_ff;
         z_dl_ff[0] <= z6_ff;
         s_dl_ff[0] <= sig6_ff;
         v_dl_ff[0] <= ok6_ff;
         for (int i = 1; i < SQD; i++) begin
            x_dl_ff[i] <= x_dl_ff[i-1];
            y_dl_ff[i] <= y_dl_ff[i-1];
            z_dl_ff[i] <= z_dl_ff[i-1];
            s_dl_ff[i] <= s_dl_ff[i-1];
            v_dl_ff[i] <= v_dl_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- final stage
   // round to nearest: the remainder exceeds the root -> step up
   logic [RW-1:0]       root_rnd;
   logic [23:0]         nrm_in;
   logic [RSP_DW-1:0]   f_data_in, f_data_ff;
   logic                f_user_ff;

   always_comb begin
      root_rnd  = (RW'(sq_n[SQ_STEPS]) > sq_r[SQ_STEPS]) ? sq_r[SQ_STEPS] + RW'(1)
                                                          : sq_r[SQ_STEPS];
      nrm_in    = (root_rnd > RW'(24'hFF_FFFF)) ? 24'hFF_FFFF : root_rnd[23:0];
      f_data_in = {5'b0, s_dl_ff[SQD-1], nrm_in, z_dl_ff[SQD-1], y_dl_ff[SQD-1],
                   x_dl_ff[SQD-1]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_data_ff <= f_data_in;
         f_user_ff <= v_dl_ff[SQD-1];
      end
   end

   // ---------------------------------------------------------------- output + skid
   logic              o_valid_ff, f_valid;
   logic              o_load_pipe, o_load_skid, sk_load;
   logic [RSP_DW-1:0] o_data_ff, sk_data_ff;
   logic              o_user_ff, sk_user_ff;

   always_comb begin
      f_valid     = vld_ff[LAT-1];
      o_load_pipe = advance && (!o_valid_ff || rsp_tready);
      sk_load     = advance && o_valid_ff && !rsp_tready && f_valid;
      o_load_skid = sk_valid_ff && rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff  <= 1'b0;
         sk_valid_ff <= 1'b0;
      end else begin
         if (o_load_pipe) begin
            o_valid_ff <= f_valid;
         end
         if (sk_load) begin
            sk_valid_ff <= 1'b1;
         end else if (o_load_skid) begin
            sk_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (o_load_pipe) begin
         o_data_ff <= f_data_ff;
         o_user_ff <= f_user_ff;
      end else if (o_load_skid) begin
         o_data_ff <= sk_data_ff;
         o_user_ff <= sk_user_ff;
      end
      if (sk_load) begin
         sk_data_ff <= f_data_ff;
         sk_user_ff <= f_user_ff;
      end
   end

   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_user_ff;
   assign rsp_tvalid = o_valid_ff;

   // ---------------------------------------------------------------- checks
   // a word parked in the skid always has one in front of it
   `LP2C_ASSERT_IMPL(a_skid_behind_out, clock, reset, sk_valid_ff, o_valid_ff)
   // a parked word stays until the output moves
   `LP2C_ASSERT_NEXT(a_skid_holds, clock, reset, sk_valid_ff && !rsp_tready, sk_valid_ff)
   // a rejected pixel carries no numbers
   `LP2C_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)
   // the norm is zero only at the origin
   `LP2C_ASSERT_IMPL(a_norm_origin, clock, reset, rsp_tvalid && rsp_tdata[98:75] == '0, rsp_tdata[74:0] == '0)

endmodule

// File: bench/tb.sv
// Self-checking bench for the lidar pixel to Cartesian point projection.
module tb
   import lp2c_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_DW      = 80;
   localparam int DRAIN_WAIT  = 60;    // pipeline is 51 deep
   localparam int IDLE_LIMIT  = 2000;  // cycles with no word moving on either side
   localparam longint unsigned TWO_PI = 64'd6746518852;
   localparam longint unsigned Q_ONE  = 64'd1 << 30;

   typedef struct {
      logic signed [24:0] x;
      logic signed [24:0] y;
      logic signed [24:0] z;
      logic [23:0]        range;
      logic [15:0]        intensity;
      logic               valid;
   } point_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic [0:0]        req_tuser = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [RSP_DW-1:0] rsp_tdata;
   logic [0:0]        rsp_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_addr = '0;
   logic [19:0]       csr_wdata = '0;

   // shadow copy of the block's registers
   logic [3:0]  cols_log2_q;
   logic [12:0] beam_offset_q;
   logic [19:0] min_range_q;
   logic [19:0] max_range_q;

   point_type point_q[$];
   int     mismatches = 0;
   int     idle_cycles = 0;
   bit     gaps_on = 1'b1;
   bit     stalls_on = 1'b1;
   int     stall_left = 0;

   always #1 clock = ~clock;

   lidar_polar_to_cartesian_point u_dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Q30 sine and cosine: octant fold plus Taylor series
   function automatic void trig_q30(input longint unsigned ang,
                                    output longint s, output longint c);
      longint unsigned q, r, x, x2, t, sn, cs, tmp;
      bit swap;
      ang = ang & 64'hFFFF;
      q = (ang >> 14) & 3;
      r = ang & 64'h3FFF;
      swap = (r > 64'h2000);
      if (swap) r = 64'h4000 - r;
      x = (r * TWO_PI) >> 16;
      x2 = (x * x) >> 30;
      t = Q_ONE;
      t = Q_ONE - ((x2 * t) >> 30) / 72;
      t = Q_ONE - ((x2 * t) >> 30) / 42;
      t = Q_ONE - ((x2 * t) >> 30) / 20;
      t = Q_ONE - ((x2 * t) >> 30) / 6;
      sn = (x * t) >> 30;
      t = Q_ONE;
      t = Q_ONE - ((x2 * t) >> 30) / 90;
      t = Q_ONE - ((x2 * t) >> 30) / 56;
      t = Q_ONE - ((x2 * t) >> 30) / 30;
      t = Q_ONE - ((x2 * t) >> 30) / 12;
      t = Q_ONE - ((x2 * t) >> 30) / 2;
      cs = t;
      if (swap) begin
         tmp = sn; sn = cs; cs = tmp;
      end
      case (q)
         0: begin s = longint'(sn);  c = longint'(cs);  end
         1: begin s = longint'(cs);  c = -longint'(sn); end
         2: begin s = -longint'(sn); c = -longint'(cs); end
         default: begin s = -longint'(cs); c = longint'(sn); end
      endcase
   endfunction

   // product with a Q30 factor, rounded half away from zero
   function automatic longint mul_q30(input longint v, input longint f);
      longint p;
      longint unsigned mag, r;
      p = v * f;
      mag = (p < 0) ? longint'(0) - p : p;
      r = (mag + (64'd1 << 29)) >> 30;
      return (p < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint clip25(input longint v);
      if (v > 16777215) return 16777215;
      if (v < -16777216) return -16777216;
      return v;
   endfunction

   function automatic longint unsigned norm_round(input longint unsigned s);
      longint unsigned r, b, n;
      r = 0;
      b = 64'd1 << 62;
      n = s;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (s - r * r > r) r = r + 1;
      return r;
   endfunction

   function automatic point_type project_point(input logic [19:0] rng, input logic [10:0] mid,
                                               input logic col_ok, input logic [15:0] alt,
                                               input logic [15:0] azi, input logic [15:0] sig);
      point_type p;
      longint unsigned cl, enc, theta, sq, nrm;
      longint d, n, h, x, y, z, sp, cp, st, ct, se, ce;
      p = '{0, 0, 0, 0, 0, 1'b0};
      if (!col_ok || rng < min_range_q || rng > max_range_q) return p;
      cl = cols_log2_q;
      if (cl < 9) cl = 9;
      if (cl > 11) cl = 11;
      enc = (64'd0 - (64'(mid) << (16 - cl))) & 64'hFFFF;
      theta = (enc - alt * 0 - azi) & 64'hFFFF;
      trig_q30(alt, sp, cp);
      trig_q30(theta, st, ct);
      trig_q30(enc, se, ce);
      n = beam_offset_q;
      d = longint'(rng) * 8 - n;
      h = mul_q30(d, cp);
      x = clip25(mul_q30(h, ct) + mul_q30(n, ce));
      y = clip25(mul_q30(h, st) + mul_q30(n, se));
      z = clip25(mul_q30(d, sp));
      sq = x * x + y * y + z * z;
      nrm = norm_round(sq);
      if (nrm > 64'hFFFFFF) nrm = 64'hFFFFFF;
      p.x = x[24:0];
      p.y = y[24:0];
      p.z = z[24:0];
      p.range = nrm[23:0];
      p.intensity = sig;
      p.valid = 1'b1;
      return p;
   endfunction

   // one pixel word; the expectation is queued once the word is taken
   task automatic send_pixel(input logic [19:0] rng, input logic [10:0] mid,
                             input logic col_ok, input logic [15:0] alt,
                             input logic [15:0] azi, input logic [15:0] sig);
      int g;
      req_tdata  <= {1'b0, sig, azi, alt, mid, rng};
      req_tuser  <= col_ok;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      point_q = {point_q, project_point(rng, mid, col_ok, alt, azi, sig)};
      g = gaps_on ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // the last word was taken at this edge, so valid drops right away
   task automatic drain();
      req_tvalid <= 1'b0;
      while (point_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // register write; only called with the pipeline empty
   task automatic write_csr(input csr_index_type idx, input logic [19:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_COLUMNS_LOG2: cols_log2_q   = val[3:0];
         CSR_BEAM_OFFSET:  beam_offset_q = val[12:0];
         CSR_MIN_RANGE:    min_range_q   = val;
         CSR_MAX_RANGE:    max_range_q   = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [19:0] cl, input logic [19:0] off,
                             input logic [19:0] lo, input logic [19:0] hi);
      drain();
      write_csr(CSR_COLUMNS_LOG2, cl);
      write_csr(CSR_BEAM_OFFSET, off);
      write_csr(CSR_MIN_RANGE, lo);
      write_csr(CSR_MAX_RANGE, hi);
   endtask

   task automatic send_random_pixel(input int valid_pct);
      logic [19:0] rng;
      int sel;
      sel = $urandom_range(0, 9);
      // mostly inside the window, some anywhere, some right on the edges
      if (sel < 6 && max_range_q >= min_range_q)
         rng = $urandom_range(max_range_q, min_range_q);
      else if (sel < 8)
         rng = $urandom();
      else
         rng = $urandom_range(0, 1) ? min_range_q : max_range_q;
      send_pixel(rng, $urandom(), ($urandom_range(0, 99) < valid_pct), $urandom(),
                 $urandom(), $urandom());
   endtask

   // reset defaults: 1024 columns, no offset, full window
   task automatic test_defaults();
      send_pixel(20'd1000, 11'd0, 1'b1, 16'd0, 16'd0, 16'd1234);
      send_pixel(20'hFFFFF, 11'd256, 1'b1, 16'h2000, 16'hE000, 16'hFFFF);
      send_pixel(20'd0, 11'd1023, 1'b1, 16'h4000, 16'h0000, 16'd0);
   endtask

   task automatic test_directed();
      set_config(20'd11, 20'd8191, 20'd100, 20'd900000);
      send_pixel(20'd100, 11'd0, 1'b1, 16'h0000, 16'h0000, 16'hFFFF);     // min edge
      send_pixel(20'd900000, 11'd2047, 1'b1, 16'h7FFF, 16'h8000, 16'h0001); // max edge
      send_pixel(20'd99, 11'd5, 1'b1, 16'h1000, 16'h1000, 16'hAAAA);      // just below
      send_pixel(20'd900001, 11'd5, 1'b1, 16'h1000, 16'h1000, 16'h5555);  // just above
      send_pixel(20'd5000, 11'd700, 1'b0, 16'h1000, 16'h1000, 16'hFFFF);  // bad column
      send_pixel(20'd5000, 11'd512, 1'b1, 16'h8000, 16'h7FFF, 16'h00FF);  // half turn
      send_pixel(20'd5000, 11'd1024, 1'b1, 16'hC000, 16'h4000, 16'hFF00);
      send_pixel(20'd101, 11'd1, 1'b1, 16'h2001, 16'h1FFF, 16'h8000);     // octant fold
      send_pixel(20'd101, 11'd1, 1'b1, 16'h2000, 16'h2000, 16'h7FFF);
      // id beyond the column count wraps
      set_config(20'd9, 20'd0, 20'd0, 20'hFFFFF);
      send_pixel(20'd70000, 11'd2047, 1'b1, 16'hFFFF, 16'h0001, 16'd42);
      send_pixel(20'hFFFFF, 11'd600, 1'b1, 16'h0000, 16'h0000, 16'd43);
      // out of range column counts clamp
      set_config(20'd0, 20'd4095, 20'd0, 20'hFFFFF);
      send_pixel(20'd12345, 11'd300, 1'b1, 16'h0800, 16'hF800, 16'd1);
      set_config(20'd15, 20'd1, 20'd0, 20'hFFFFF);
      send_pixel(20'd12345, 11'd300, 1'b1, 16'h0800, 16'hF800, 16'd2);
      // crossed limits: nothing accepted; also equal limits
      set_config(20'd10, 20'd0, 20'd5000, 20'd4999);
      send_pixel(20'd5000, 11'd3, 1'b1, 16'h0100, 16'h0100, 16'd3);
      send_pixel(20'd4999, 11'd3, 1'b1, 16'h0100, 16'h0100, 16'd4);
      set_config(20'd10, 20'd0, 20'd5000, 20'd5000);
      send_pixel(20'd5000, 11'd3, 1'b1, 16'h0100, 16'h0100, 16'd5);
      // offset larger than 8*range gives a negative distance
      set_config(20'd10, 20'd8191, 20'd0, 20'hFFFFF);
      send_pixel(20'd0, 11'd100, 1'b1, 16'h0200, 16'h0300, 16'd6);
      send_pixel(20'd500, 11'd900, 1'b1, 16'hFE00, 16'hFD00, 16'd7);
   endtask

   task automatic test_random_configs();
      int phase, k;
      for (phase = 0; phase < 10; phase++) begin
         gaps_on   = (phase % 4 != 3);
         stalls_on = (phase % 4 != 2);
         case (phase)
            0: set_config(20'd9, 20'd0, 20'd0, 20'hFFFFF);
            1: set_config(20'd11, 20'd8191, 20'd0, 20'hFFFFF);
            2: set_config(20'd10, $urandom(), $urandom_range(0, 500000),
                          $urandom_range(500000, 1048575));
            default: set_config($urandom(), $urandom(), $urandom_range(0, 300000),
                                $urandom_range(200000, 1048575));
         endcase
         for (k = 0; k < 73; k++) send_random_pixel(phase == 5 ? 50 : 90);
      end
      gaps_on = 1'b1;
      stalls_on = 1'b1;
   endtask

   // result side back pressure
   always @(posedge clock) begin
      if (!stalls_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_left <= gap_len();
         rsp_tready <= 1'b1;
      end
   end

   // compare each result word with the oldest queued point
   always @(posedge clock) begin
      point_type e;
      logic signed [24:0] ax, ay, az;
      logic [23:0] ar;
      logic [15:0] ai;
      if (!reset && rsp_tvalid && rsp_tready) begin
         ax = rsp_tdata[24:0];
         ay = rsp_tdata[49:25];
         az = rsp_tdata[74:50];
         ar = rsp_tdata[98:75];
         ai = rsp_tdata[114:99];
         if (point_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: x=%0d y=%0d z=%0d", ax, ay, az);
         end else begin
            e = point_q.pop_front();
            if (ax !== e.x || ay !== e.y || az !== e.z || ar !== e.range ||
                ai !== e.intensity || rsp_tuser[0] !== e.valid) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp x=%0d y=%0d z=%0d r=%0d i=%0d v=%0b",
                           e.x, e.y, e.z, e.range, e.intensity, e.valid);
                  $display("          got x=%0d y=%0d z=%0d r=%0d i=%0d v=%0b",
                           ax, ay, az, ar, ai, rsp_tuser[0]);
               end
            end
         end
      end
   end

   // watchdog on cycles where neither side moves a word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      cols_log2_q   = 4'd10;
      beam_offset_q = 13'd0;
      min_range_q   = 20'd0;
      max_range_q   = 20'hFFFFF;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_directed();
      test_random_configs();
      drain();
      if (mismatches == 0 && point_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
